### hw/rtl/stpq_pkg.sv
// ----------------------------------------------------------------------------
// Stable three-level priority queue package
// Shared types, codes and helper functions of the queue core and its cells.
// ----------------------------------------------------------------------------
package stpq_pkg;

	localparam int STPQ_CAPACITY = 16;

	localparam int TAG_W   = 16;
	localparam int VAL_W   = 7;
	localparam int LEVEL_W = 2;
	localparam int COUNT_W = 5;
	localparam int CFG_IDX_W = 4;

	localparam logic [VAL_W-1:0] URGENT_VITAL_RESET = 7'd10;
	localparam logic [VAL_W-1:0] SENIOR_AGE_RESET   = 7'd55;
	localparam logic [VAL_W-1:0] MIN_AGE_CEILING    = 7'd100;
	localparam logic [VAL_W-1:0] AGE_LOWEST         = 7'd0;
	localparam logic [VAL_W-1:0] AGE_HIGHEST        = 7'd127;

	localparam logic KIND_ENQUEUE = 1'b0;
	localparam logic KIND_DEQUEUE = 1'b1;

	localparam logic [LEVEL_W-1:0] LEVEL_NONE   = 2'd0;
	localparam logic [LEVEL_W-1:0] LEVEL_URGENT = 2'd1;
	localparam logic [LEVEL_W-1:0] LEVEL_SENIOR = 2'd2;
	localparam logic [LEVEL_W-1:0] LEVEL_NORMAL = 2'd3;

	localparam logic [CFG_IDX_W-1:0] CFG_URGENT_VITAL_BELOW = 4'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SENIOR_AGE_ABOVE   = 4'd1;

	typedef struct packed {
		logic [TAG_W-1:0]   tag;
		logic [VAL_W-1:0]   age;
		logic [VAL_W-1:0]   vital;
		logic [VAL_W-1:0]   mp;
		logic [LEVEL_W-1:0] level;
	} entry_t;

	typedef struct packed {
		logic [VAL_W-1:0] max_age;
		logic [VAL_W-1:0] min_age;
	} stat_t;

	localparam stat_t STAT_EMPTY = '{max_age: AGE_LOWEST, min_age: AGE_HIGHEST};

	typedef struct packed {
		logic enq;
		logic deq;
	} cell_ctl_t;

	typedef struct packed {
		logic             kind;
		logic [TAG_W-1:0] patient_tag;
		logic [VAL_W-1:0] patient_age;
		logic [VAL_W-1:0] patient_vital;
		logic [VAL_W-1:0] patient_mp;
	} req_t;

	typedef struct packed {
		logic               served_valid;
		logic [TAG_W-1:0]   served_tag;
		logic [VAL_W-1:0]   served_age;
		logic [VAL_W-1:0]   served_vital;
		logic [VAL_W-1:0]   served_mp;
		logic [LEVEL_W-1:0] served_level;
		logic               enqueue_dropped;
		logic [COUNT_W-1:0] queue_count;
		logic [VAL_W-1:0]   max_age;
		logic [VAL_W-1:0]   min_age;
	} rsp_t;

	typedef struct packed {
		logic [CFG_IDX_W-1:0] index;
		logic [VAL_W-1:0]     data;
	} cfg_t;

	function automatic logic [LEVEL_W-1:0] level_of(
		input logic [VAL_W-1:0] age,
		input logic [VAL_W-1:0] vital,
		input logic [VAL_W-1:0] urgent_vital_below,
		input logic [VAL_W-1:0] senior_age_above
	);
		logic [LEVEL_W-1:0] lvl;
		if (vital < urgent_vital_below) begin
			lvl = LEVEL_URGENT;
		end else if (age > senior_age_above) begin
			lvl = LEVEL_SENIOR;
		end else begin
			lvl = LEVEL_NORMAL;
		end
		return lvl;
	endfunction

	function automatic stat_t stat_merge(input stat_t s, input logic [VAL_W-1:0] age);
		stat_t r;
		r.max_age = (age > s.max_age) ? age : s.max_age;
		r.min_age = (age < s.min_age) ? age : s.min_age;
		return r;
	endfunction

endpackage

### hw/rtl/stpq_stream_if.sv
// ----------------------------------------------------------------------------
// Valid/ready stream interface
// One beat moves at a rising edge with valid and ready both high.
// ----------------------------------------------------------------------------
interface stpq_stream_if #(
	parameter type payload_t = logic
) ();
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

### hw/rtl/stable_three_level_priority_queue_core.sv
// Latency: a result is registered at the edge that takes its request beat and is
// offered in the next cycle. Throughput: one request per cycle while results are
// taken; a stalled result holds the request side. Insert and pop each finish in
// that cycle in the row of cells, and the age range rides along with the data.
// Reset: arst_n clears the count and result valid flag and sets the thresholds
// (10 and 55); cell contents are not cleared and there is no clearing pass.
// ----------------------------------------------------------------------------
// Stable three-level priority queue core
// Ordered row of cells with first-in first-out order within each level.
// ----------------------------------------------------------------------------
module stable_three_level_priority_queue_core #(
	parameter int CAPACITY = stpq_pkg::STPQ_CAPACITY
) (
	input logic          clk,
	input logic          arst_n,
	stpq_stream_if.sink  req,
	stpq_stream_if.source rsp,
	stpq_stream_if.sink  cfg
);
	import stpq_pkg::*;

	localparam int CW = $clog2(CAPACITY + 1);

	logic [CW-1:0]    count_q;
	logic [CW-1:0]    count_d;
	logic [VAL_W-1:0] urgent_q;
	logic [VAL_W-1:0] senior_q;
	logic             rsp_valid_q;
	rsp_t             rsp_q;
	rsp_t             rsp_d;

	logic      accept;
	logic      full;
	logic      empty;
	cell_ctl_t ctl;
	entry_t    new_entry;
	stat_t     head_stat;

	logic   gt_w    [CAPACITY+1];
	entry_t entry_w [CAPACITY+2];
	stat_t  stat_w  [CAPACITY+2];
	stat_t  stat_nx_w [CAPACITY];

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			urgent_q <= URGENT_VITAL_RESET;
			senior_q <= SENIOR_AGE_RESET;
		end else if (cfg.valid) begin
			unique case (cfg.payload.index)
				CFG_URGENT_VITAL_BELOW: urgent_q <= cfg.payload.data;
				CFG_SENIOR_AGE_ABOVE:   senior_q <= cfg.payload.data;
				default: ;
			endcase
		end
	end

	assign req.ready = !rsp_valid_q || rsp.ready;
	assign accept    = req.valid && req.ready;
	assign full      = (count_q == CW'(CAPACITY));
	assign empty     = (count_q == '0);

	assign ctl.enq = accept && (req.payload.kind == KIND_ENQUEUE) && !full;
	assign ctl.deq = accept && (req.payload.kind == KIND_DEQUEUE) && !empty;

	assign new_entry.tag   = req.payload.patient_tag;
	assign new_entry.age   = req.payload.patient_age;
	assign new_entry.vital = req.payload.patient_vital;
	assign new_entry.mp    = req.payload.patient_mp;
	assign new_entry.level = level_of(req.payload.patient_age, req.payload.patient_vital,
		urgent_q, senior_q);

	assign gt_w[0]              = 1'b0;
	assign entry_w[0]           = new_entry;
	assign stat_w[0]            = STAT_EMPTY;
	assign entry_w[CAPACITY+1]  = new_entry;
	assign stat_w[CAPACITY+1]   = STAT_EMPTY;

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		stpq_cell u_cell (
			.clk         (clk),
			.ctl         (ctl),
			.new_entry   (new_entry),
			.occ         (CW'(i) < count_q),
			.left_gt     (gt_w[i]),
			.left_entry  (entry_w[i]),
			.left_stat   (stat_w[i]),
			.right_entry (entry_w[i+2]),
			.right_stat  (stat_w[i+2]),
			.gt          (gt_w[i+1]),
			.entry       (entry_w[i+1]),
			.stat        (stat_w[i+1]),
			.stat_nx     (stat_nx_w[i])
		);
	end

	assign head_stat = stat_nx_w[0];

	always_comb begin
		count_d = count_q;
		priority if (ctl.enq) begin
			count_d = count_q + CW'(1);
		end else if (ctl.deq) begin
			count_d = count_q - CW'(1);
		end
	end

	always_comb begin
		rsp_d                 = '0;
		rsp_d.served_valid    = ctl.deq;
		rsp_d.enqueue_dropped = (req.payload.kind == KIND_ENQUEUE) && full;
		if (ctl.deq) begin
			rsp_d.served_tag   = entry_w[1].tag;
			rsp_d.served_age   = entry_w[1].age;
			rsp_d.served_vital = entry_w[1].vital;
			rsp_d.served_mp    = entry_w[1].mp;
			rsp_d.served_level = entry_w[1].level;
		end
		rsp_d.queue_count = COUNT_W'(count_d);
		rsp_d.max_age     = head_stat.max_age;
		rsp_d.min_age     = (head_stat.min_age < MIN_AGE_CEILING) ? head_stat.min_age
			: MIN_AGE_CEILING;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			count_q <= count_d;
			if (req.ready) begin
				rsp_valid_q <= accept;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			rsp_q <= rsp_d;
		end
	end

	assign rsp.valid   = rsp_valid_q;
	assign rsp.payload = rsp_q;

endmodule

### hw/rtl/stpq_cell.sv
// ----------------------------------------------------------------------------
// Priority queue cell
// Holds one entry and the age range of itself and every entry behind it;
// on an insert takes the new entry or its left neighbour's, on a pop its right one's.
// ----------------------------------------------------------------------------
module stpq_cell (
	input  logic                clk,
	input  stpq_pkg::cell_ctl_t ctl,
	input  stpq_pkg::entry_t    new_entry,
	input  logic                occ,
	input  logic                left_gt,
	input  stpq_pkg::entry_t    left_entry,
	input  stpq_pkg::stat_t     left_stat,
	input  stpq_pkg::entry_t    right_entry,
	input  stpq_pkg::stat_t     right_stat,
	output logic                gt,
	output stpq_pkg::entry_t    entry,
	output stpq_pkg::stat_t     stat,
	output stpq_pkg::stat_t     stat_nx
);
	import stpq_pkg::*;

	entry_t entry_q;
	entry_t entry_d;
	stat_t  stat_q;
	stat_t  merged;

	assign gt     = !occ || (entry_q.level > new_entry.level);
	assign entry  = entry_q;
	assign stat   = occ ? stat_q : STAT_EMPTY;
	assign merged = stat_merge(stat, new_entry.age);

	always_comb begin
		entry_d = entry_q;
		stat_nx = stat;
		priority if (ctl.enq) begin
			if (gt && left_gt) begin
				entry_d = left_entry;
				stat_nx = left_stat;
			end else if (gt) begin
				entry_d = new_entry;
				stat_nx = merged;
			end else begin
				stat_nx = merged;
			end
		end else if (ctl.deq) begin
			entry_d = right_entry;
			stat_nx = right_stat;
		end
	end

	always_ff @(posedge clk) begin
		entry_q <= entry_d;
		stat_q  <= stat_nx;
	end

endmodule

### hw/rtl/stpq_checker.sv
// ----------------------------------------------------------------------------
// Priority queue port checker
// Watches the result channel of the queue core; bound into the queue core.
// ----------------------------------------------------------------------------
module stpq_checker #(
	parameter int CAPACITY = stpq_pkg::STPQ_CAPACITY
) (
	input logic           clk,
	input logic           arst_n,
	input logic           rsp_valid,
	input logic           rsp_ready,
	input stpq_pkg::rsp_t rsp_payload
);
	import stpq_pkg::*;

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))
		else $error("Result beat changed while stalled.");

	a_level_matches_served: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (rsp_payload.served_valid == (rsp_payload.served_level != LEVEL_NONE)))
		else $error("Served level disagrees with served flag.");

	a_drop_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_payload.enqueue_dropped |->
			!rsp_payload.served_valid && (rsp_payload.queue_count == COUNT_W'(CAPACITY)))
		else $error("Enqueue dropped while the queue was not full.");

	a_age_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp_payload.queue_count != '0) |->
			(rsp_payload.min_age <= rsp_payload.max_age) &&
			(rsp_payload.min_age <= MIN_AGE_CEILING))
		else $error("Reported age range is inconsistent.");

	a_empty_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (CAPACITY < 32) && (rsp_payload.queue_count == '0) |->
			(rsp_payload.max_age == AGE_LOWEST) && (rsp_payload.min_age == MIN_AGE_CEILING))
		else $error("Empty queue reported a non-empty age range.");

endmodule

bind stable_three_level_priority_queue_core stpq_checker #(.CAPACITY(CAPACITY)) u_stpq_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.rsp_valid   (rsp.valid),
	.rsp_ready   (rsp.ready),
	.rsp_payload (rsp.payload)
);

### bench/stable_three_level_priority_queue_core_tb.sv
// ----------------------------------------------------------------------------
// Stable three-level priority queue core testbench
// Drives enqueue and dequeue beats with random bursts and gaps, stalls the
// result side, and checks every result against a behavioural copy of the
// ordered queue that is kept inside the bench.
// ----------------------------------------------------------------------------
module stable_three_level_priority_queue_core_tb;

	import stpq_pkg::*;

	localparam int CAPACITY = STPQ_CAPACITY;
	localparam int PHASES = 5;
	localparam int ITEMS_PER_PHASE = 90;
	localparam int LONG_HOLD_CYCLES = 200;
	localparam int CYCLE_LIMIT = 100000;
	localparam int MAX_PRINTED = 40;
	localparam logic [CFG_IDX_W-1:0] CFG_FIRST_UNUSED = CFG_SENIOR_AGE_ABOVE + 1'b1;
	localparam logic [CFG_IDX_W-1:0] CFG_LAST_UNUSED = '1;

	logic clk;
	logic arst_n;

	stpq_stream_if #(.payload_t(req_t)) req_if ();
	stpq_stream_if #(.payload_t(rsp_t)) rsp_if ();
	stpq_stream_if #(.payload_t(cfg_t)) cfg_if ();

	stable_three_level_priority_queue_core #(
		.CAPACITY(CAPACITY)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_if),
		.rsp(rsp_if),
		.cfg(cfg_if)
	);

	req_t waiting_patients[$];
	rsp_t awaited_reports[$];
	entry_t ward_line[$];
	logic [VAL_W-1:0] urgent_below;
	logic [VAL_W-1:0] senior_above;

	int error_count = 0;
	int cycle_count = 0;
	int burst_left;
	int gap_left;
	logic offering;
	logic [4:0] stall_pos;
	logic [31:0] stall_bits;
	logic rsp_hold;
	logic long_hold_start = 1'b0;

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	function automatic rsp_t triage_step(input req_t r);
		rsp_t o;
		entry_t e;
		int pos;
		logic [VAL_W-1:0] oldest;
		logic [VAL_W-1:0] youngest;
		o = '0;
		if (r.kind == KIND_ENQUEUE) begin
			e.tag = r.patient_tag;
			e.age = r.patient_age;
			e.vital = r.patient_vital;
			e.mp = r.patient_mp;
			if (r.patient_vital < urgent_below) begin
				e.level = LEVEL_URGENT;
			end else if (r.patient_age > senior_above) begin
				e.level = LEVEL_SENIOR;
			end else begin
				e.level = LEVEL_NORMAL;
			end
			if (ward_line.size() >= CAPACITY) begin
				o.enqueue_dropped = 1'b1;
			end else begin
				pos = ward_line.size();
				for (int i = 0; i < ward_line.size(); i++) begin
					if (ward_line[i].level > e.level) begin
						pos = i;
						break;
					end
				end
				ward_line.insert(pos, e);
			end
		end else if (ward_line.size() > 0) begin
			e = ward_line.pop_front();
			o.served_valid = 1'b1;
			o.served_tag = e.tag;
			o.served_age = e.age;
			o.served_vital = e.vital;
			o.served_mp = e.mp;
			o.served_level = e.level;
		end
		oldest = AGE_LOWEST;
		youngest = MIN_AGE_CEILING;
		foreach (ward_line[i]) begin
			if (ward_line[i].age > oldest) begin
				oldest = ward_line[i].age;
			end
			if (ward_line[i].age < youngest) begin
				youngest = ward_line[i].age;
			end
		end
		o.queue_count = COUNT_W'(ward_line.size());
		o.max_age = oldest;
		o.min_age = youngest;
		return o;
	endfunction

	function automatic req_t patient(input logic kind, input logic [TAG_W-1:0] tag,
			input logic [VAL_W-1:0] age, input logic [VAL_W-1:0] vital,
			input logic [VAL_W-1:0] mp);
		req_t r;
		r.kind = kind;
		r.patient_tag = tag;
		r.patient_age = age;
		r.patient_vital = vital;
		r.patient_mp = mp;
		return r;
	endfunction

	function automatic req_t random_patient(input int enq_pct);
		req_t r;
		r.kind = ($urandom_range(0, 99) < enq_pct) ? KIND_ENQUEUE : KIND_DEQUEUE;
		r.patient_tag = TAG_W'($urandom());
		r.patient_mp = VAL_W'($urandom());
		// Values close to the thresholds exercise the level boundaries.
		if ($urandom_range(0, 3) == 0) begin
			r.patient_age = VAL_W'(int'(senior_above) + $urandom_range(0, 2) - 1);
		end else begin
			r.patient_age = VAL_W'($urandom());
		end
		if ($urandom_range(0, 3) == 0) begin
			r.patient_vital = VAL_W'(int'(urgent_below) + $urandom_range(0, 2) - 1);
		end else begin
			r.patient_vital = VAL_W'($urandom());
		end
		return r;
	endfunction

	task automatic report_mismatch(input string what, input int got, input int want);
		if (error_count < MAX_PRINTED) begin
			$display("MISMATCH %s: got %0d, expected %0d (cycle %0d)", what, got, want,
				cycle_count);
		end
		error_count++;
	endtask

	task automatic check_field(input string what, input int got, input int want);
		if (got != want) begin
			report_mismatch(what, got, want);
		end
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [VAL_W-1:0] value);
		@(posedge clk);
		cfg_if.valid <= 1'b1;
		cfg_if.payload <= '{index: idx, data: value};
		do @(posedge clk); while (!cfg_if.ready);
		if (idx == CFG_URGENT_VITAL_BELOW) begin
			urgent_below = value;
		end else if (idx == CFG_SENIOR_AGE_ABOVE) begin
			senior_above = value;
		end
		cfg_if.valid <= 1'b0;
	endtask

	task automatic wait_drained();
		while (waiting_patients.size() != 0 || awaited_reports.size() != 0 || req_if.valid) begin
			@(posedge clk);
		end
	endtask

	// Request driver: bursts of random length separated by random gaps.
	// A beat on offer is held until it is taken.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_if.valid <= 1'b0;
			req_if.payload <= '0;
			burst_left = 0;
			gap_left = 0;
		end else begin
			offering = req_if.valid;
			if (req_if.valid && req_if.ready) begin
				awaited_reports.push_back(triage_step(waiting_patients.pop_front()));
				offering = 1'b0;
				if (burst_left > 0) begin
					burst_left--;
				end
			end
			if (!offering) begin
				if (burst_left == 0 && gap_left == 0) begin
					burst_left = $urandom_range(1, 24);
					gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 7);
				end
				if (gap_left > 0) begin
					gap_left--;
					req_if.valid <= 1'b0;
				end else if (waiting_patients.size() > 0) begin
					req_if.valid <= 1'b1;
					req_if.payload <= waiting_patients[0];
				end else begin
					req_if.valid <= 1'b0;
				end
			end
		end
	end

	// Result monitor: checks each taken beat and stalls on a 32-bit pattern that is
	// redrawn whenever its bit position wraps around, and also during the long hold.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_if.ready <= 1'b0;
			stall_pos = '0;
			stall_bits = '0;
		end else begin
			if (rsp_if.valid && rsp_if.ready) begin
				if (awaited_reports.size() == 0) begin
					report_mismatch("result beat with no request outstanding", 1, 0);
				end else begin
					automatic rsp_t want = awaited_reports.pop_front();
					automatic rsp_t got = rsp_if.payload;
					check_field("served_valid", got.served_valid, want.served_valid);
					check_field("served_tag", got.served_tag, want.served_tag);
					check_field("served_age", got.served_age, want.served_age);
					check_field("served_vital", got.served_vital, want.served_vital);
					check_field("served_mp", got.served_mp, want.served_mp);
					check_field("served_level", got.served_level, want.served_level);
					check_field("enqueue_dropped", got.enqueue_dropped, want.enqueue_dropped);
					check_field("queue_count", got.queue_count, want.queue_count);
					check_field("max_age", got.max_age, want.max_age);
					check_field("min_age", got.min_age, want.min_age);
				end
			end
			if (stall_pos == '0) begin
				case ($urandom_range(0, 3))
					0: stall_bits = '0;
					1: stall_bits = $urandom() & $urandom();
					2: stall_bits = $urandom();
					default: stall_bits = 32'h8888_8888;
				endcase
			end
			rsp_if.ready <= !rsp_hold && !stall_bits[stall_pos];
			stall_pos = stall_pos + 1'b1;
		end
	end

	initial begin
		rsp_hold = 1'b0;
		wait (long_hold_start);
		@(posedge clk);
		rsp_hold <= 1'b1;
		repeat (LONG_HOLD_CYCLES) @(posedge clk);
		rsp_hold <= 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	initial begin
		int vital_cut[PHASES];
		int age_cut[PHASES];
		int enq_share[PHASES];
		vital_cut = '{0, 127, 64, 0, 1};
		age_cut = '{0, 127, 30, 0, 126};
		enq_share = '{65, 50, 75, 40, 55};
		clk = 1'b0;
		arst_n = 1'b0;
		req_if.valid = 1'b0;
		req_if.payload = '0;
		rsp_if.ready = 1'b0;
		cfg_if.valid = 1'b0;
		cfg_if.payload = '0;
		urgent_below = URGENT_VITAL_RESET;
		senior_above = SENIOR_AGE_RESET;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// Directed part with the thresholds left at their reset values.
		waiting_patients.push_back(patient(KIND_DEQUEUE, '1, '1, '1, '1));
		waiting_patients.push_back(patient(KIND_ENQUEUE, 16'h1234, 7'd120, 7'd60, 7'd5));
		waiting_patients.push_back(patient(KIND_ENQUEUE, '0, '0, '0, '0));
		waiting_patients.push_back(patient(KIND_ENQUEUE, '1, '1, '1, '1));
		waiting_patients.push_back(patient(KIND_ENQUEUE, 16'h0055, 7'd55, 7'd10, 7'd1));
		waiting_patients.push_back(patient(KIND_ENQUEUE, 16'h0056, 7'd56, 7'd9, 7'd2));
		waiting_patients.push_back(patient(KIND_ENQUEUE, 16'h5555, 7'd55, 7'd127, 7'd64));
		repeat (3) waiting_patients.push_back(patient(KIND_DEQUEUE, '0, '0, '0, '0));
		for (int i = 0; i < 13; i++) begin
			waiting_patients.push_back(patient(KIND_ENQUEUE, TAG_W'(16'hA000 + i),
				(i % 3 == 2) ? 7'd20 : VAL_W'(101 + 2 * i),
				(i % 3 == 0) ? 7'd3 : 7'd40, VAL_W'(i)));
		end
		waiting_patients.push_back(patient(KIND_ENQUEUE, 16'hDEAD, 7'd70, 7'd0, 7'd9));
		waiting_patients.push_back(patient(KIND_DEQUEUE, '0, '0, '0, '0));

		for (int ph = 0; ph < PHASES; ph++) begin
			wait_drained();
			write_reg(CFG_URGENT_VITAL_BELOW,
				(ph == 3) ? VAL_W'($urandom()) : VAL_W'(vital_cut[ph]));
			write_reg(CFG_SENIOR_AGE_ABOVE,
				(ph == 3) ? VAL_W'($urandom()) : VAL_W'(age_cut[ph]));
			if (ph == 2) begin
				write_reg(CFG_FIRST_UNUSED, VAL_W'($urandom()));
				write_reg(CFG_LAST_UNUSED, VAL_W'($urandom()));
			end
			for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
				waiting_patients.push_back(random_patient(enq_share[ph]));
			end
			if (ph == 0) begin
				long_hold_start = 1'b1;
			end
		end

		wait_drained();
		repeat (4) @(posedge clk);
		if (error_count == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule

### filelist.f
hw/rtl/stpq_pkg.sv
hw/rtl/stpq_stream_if.sv
hw/rtl/stpq_cell.sv
hw/rtl/stable_three_level_priority_queue_core.sv
hw/rtl/stpq_checker.sv
bench/stable_three_level_priority_queue_core_tb.sv
